// ===== hw/rtl/bmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Boolean matrix product package
// Shared command codes, transaction types and the command and status groups
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bmp_pkg;

  // Command codes carried in the cmd field of an input transaction.
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_LEFT    = 3'd1;
  localparam logic [2:0] CMD_EDGE    = 3'd2;
  localparam logic [2:0] CMD_RIGHT   = 3'd3;
  localparam logic [2:0] CMD_COMPUTE = 3'd4;

  // One input transaction.
  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] row_index;
    logic [5:0] col_index;
  } in_item_t;

  // One result transaction: a single row of the product.
  typedef struct packed {
    logic [5:0]  out_row;
    logic [63:0] row_bits;
    logic        last_row;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch row and column of the accepted transaction
    logic clear;      // invalidate every row of both matrices
    logic mem_rd;     // read the row to be updated
    logic mem_wr;     // write the row back with the new bit set
    logic use_right;  // the update targets the right matrix
    logic swap;       // mirrored half of an edge: row and column exchanged
    logic i_clr;      // restart the product at row 0
    logic i_inc;      // move on to the next product row
    logic row_start;  // read the left row, clear accumulator and sweep count
    logic sweep;      // read one right row and advance the sweep count
    logic out_load;   // load the finished row into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_ok;      // both indices of the offered transaction are in range
    logic k_last;     // sweep count is on the last right row
    logic i_last;     // product row count is on the last row
    logic out_free;   // output register can take a new row this cycle
  } dp_status_t;

endpackage

// ===== hw/rtl/bmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Boolean matrix product controller
// Sequences bit updates as read-modify-write pairs and walks the product one
// row at a time, sweeping the right matrix for each row.
// ----------------------------------------------------------------------------
module bmp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [2:0]           cmd_code,
  output logic                 in_stall,
  input  bmp_pkg::dp_status_t  sts,
  output bmp_pkg::dp_cmd_t     ctl
);
  import bmp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L1_RD,
    ST_L1_WR,
    ST_L2_RD,
    ST_L2_WR,
    ST_R_RD,
    ST_R_WR,
    ST_C_ROW,
    ST_C_SWEEP,
    ST_C_DRAIN,
    ST_C_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   edge_r, edge_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state and commands to the datapath.
  always_comb begin
    state_nxt = state_r;
    edge_nxt  = edge_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_code)
            CMD_CLEAR: begin
              ctl.clear = 1'b1;
            end
            CMD_LEFT: begin
              if (sts.in_ok) begin
                ctl.capture = 1'b1;
                edge_nxt    = 1'b0;
                state_nxt   = ST_L1_RD;
              end
            end
            CMD_EDGE: begin
              if (sts.in_ok) begin
                ctl.capture = 1'b1;
                edge_nxt    = 1'b1;
                state_nxt   = ST_L1_RD;
              end
            end
            CMD_RIGHT: begin
              if (sts.in_ok) begin
                ctl.capture = 1'b1;
                state_nxt   = ST_R_RD;
              end
            end
            CMD_COMPUTE: begin
              ctl.i_clr = 1'b1;
              state_nxt = ST_C_ROW;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_L1_RD: begin
        ctl.mem_rd = 1'b1;
        state_nxt  = ST_L1_WR;
      end
      ST_L1_WR: begin
        ctl.mem_wr = 1'b1;
        state_nxt  = edge_r ? ST_L2_RD : ST_IDLE;
      end
      ST_L2_RD: begin
        ctl.mem_rd = 1'b1;
        ctl.swap   = 1'b1;
        state_nxt  = ST_L2_WR;
      end
      ST_L2_WR: begin
        ctl.mem_wr = 1'b1;
        ctl.swap   = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_R_RD: begin
        ctl.mem_rd    = 1'b1;
        ctl.use_right = 1'b1;
        state_nxt     = ST_R_WR;
      end
      ST_R_WR: begin
        ctl.mem_wr    = 1'b1;
        ctl.use_right = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_C_ROW: begin
        ctl.row_start = 1'b1;
        state_nxt     = ST_C_SWEEP;
      end
      ST_C_SWEEP: begin
        ctl.sweep = 1'b1;
        if (sts.k_last) begin
          state_nxt = ST_C_DRAIN;
        end
      end
      ST_C_DRAIN: begin
        // The final right row is folded into the accumulator this cycle.
        state_nxt = ST_C_EMIT;
      end
      ST_C_EMIT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          if (sts.i_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ctl.i_inc = 1'b1;
            state_nxt = ST_C_ROW;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      edge_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      edge_r  <= edge_nxt;
    end
  end

endmodule

// ===== hw/rtl/bmp_datapath.sv =====
// ----------------------------------------------------------------------------
// Boolean matrix product datapath
// Holds both bit matrices as row memories with per-row valid bits, the
// row and column counters, the OR accumulator and the output register.
// ----------------------------------------------------------------------------
module bmp_datapath #(
  parameter int NODES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bmp_pkg::in_item_t    in_data,
  input  bmp_pkg::dp_cmd_t     ctl,
  output bmp_pkg::dp_status_t  sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bmp_pkg::out_item_t   out_data
);
  import bmp_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [NODES-1:0] BIT0 = {{(NODES-1){1'b0}}, 1'b1};
  localparam logic [AW-1:0]    LAST = AW'(NODES - 1);

  logic [NODES-1:0] left_mem  [NODES];
  logic [NODES-1:0] right_mem [NODES];
  logic [NODES-1:0] l_valid_r;
  logic [NODES-1:0] r_valid_r;
  logic [NODES-1:0] l_rd_r;
  logic [NODES-1:0] r_rd_r;
  logic [AW-1:0]    row_r;
  logic [AW-1:0]    col_r;
  logic [AW-1:0]    i_r;
  logic [AW-1:0]    k_r;
  logic [AW-1:0]    k_d_r;
  logic             pend_r;
  logic [NODES-1:0] acc_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic [AW-1:0]    rmw_addr;
  logic [AW-1:0]    rmw_bit;
  logic [AW-1:0]    l_addr;
  logic [AW-1:0]    r_addr;
  logic [NODES-1:0] set_mask;
  logic             l_rd_en;
  logic             r_rd_en;

  // Address and bit selection; the mirrored half of an edge swaps the two.
  assign rmw_addr = ctl.swap ? col_r : row_r;
  assign rmw_bit  = ctl.swap ? row_r : col_r;
  assign set_mask = BIT0 << rmw_bit;
  assign l_addr   = ctl.row_start ? i_r : rmw_addr;
  assign r_addr   = ctl.sweep ? k_r : row_r;
  assign l_rd_en  = (ctl.mem_rd && !ctl.use_right) || ctl.row_start;
  assign r_rd_en  = (ctl.mem_rd && ctl.use_right) || ctl.sweep;

  // Matrix memories: one registered read and one write per cycle each.
  // A row that has not been written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (ctl.mem_wr && !ctl.use_right) begin
      left_mem[rmw_addr] <= l_rd_r | set_mask;
    end
    if (ctl.mem_wr && ctl.use_right) begin
      right_mem[row_r] <= r_rd_r | set_mask;
    end
    if (l_rd_en) begin
      l_rd_r <= l_valid_r[l_addr] ? left_mem[l_addr] : '0;
    end
    if (r_rd_en) begin
      r_rd_r <= r_valid_r[r_addr] ? right_mem[r_addr] : '0;
    end
  end

  // Row valid bits, cleared together by reset or the clear command.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      l_valid_r <= '0;
      r_valid_r <= '0;
    end else if (ctl.mem_wr) begin
      if (ctl.use_right) begin
        r_valid_r[row_r] <= 1'b1;
      end else begin
        l_valid_r[rmw_addr] <= 1'b1;
      end
    end
  end

  // Indices of the accepted transaction.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      row_r <= in_data.row_index[AW-1:0];
      col_r <= in_data.col_index[AW-1:0];
    end
  end

  // Product row and sweep counters, and the delayed sweep position that
  // lines up with the registered right-row read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r    <= '0;
      k_r    <= '0;
      k_d_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      if (ctl.i_clr) begin
        i_r <= '0;
      end else if (ctl.i_inc) begin
        i_r <= i_r + 1'b1;
      end
      if (ctl.row_start) begin
        k_r <= '0;
      end else if (ctl.sweep) begin
        k_r <= k_r + 1'b1;
      end
      k_d_r  <= k_r;
      pend_r <= ctl.sweep;
    end
  end

  // OR in each right row whose position is set in the left row.
  always_ff @(posedge clk) begin
    if (ctl.row_start) begin
      acc_r <= '0;
    end else if (pend_r && l_rd_r[k_d_r]) begin
      acc_r <= acc_r | r_rd_r;
    end
  end

  // Output register: holds a finished row until its transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r.out_row  <= 6'(i_r);
      out_data_r.row_bits <= 64'(acc_r);
      out_data_r.last_row <= (i_r == LAST);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to the controller.
  assign sts.in_ok    = (32'(in_data.row_index) < NODES) && (32'(in_data.col_index) < NODES);
  assign sts.k_last   = (k_r == LAST);
  assign sts.i_last   = (i_r == LAST);
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// ===== hw/rtl/boolean_matrix_product.sv =====
// ----------------------------------------------------------------------------
// Boolean matrix product
// Top level: controller and datapath for the product of two bit matrices.
// ----------------------------------------------------------------------------
// The block holds a left and a right NODES x NODES bit matrix, loaded one
// bit per transaction, and on a compute transaction returns their boolean
// product one row per result transaction, rows 0 to NODES-1, the last row
// marked. Bit updates are read-modify-write operations on row memories
// with one read and one write port each: a left or right bit is one such
// pair and a symmetric edge two, while a clear needs none. Each product
// row sweeps the right matrix one row per cycle through its one read port.
// Indices at or beyond NODES make a set or edge command do nothing, as do
// unused command codes. Results wait in an output register while new
// transactions are accepted.
// ----------------------------------------------------------------------------
module boolean_matrix_product #(
  parameter int NODES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bmp_pkg::out_item_t  out_data
);
  import bmp_pkg::*;

  dp_cmd_t    ctl;
  dp_status_t sts;

  // Sequencing.
  bmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cmd_code (in_data.cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Storage and product logic.
  bmp_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A result is only produced while the block is busy with a compute.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> in_stall)
    else $error("result loaded while input side idle");

  // A new row must never overwrite one that is still waiting.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // An accepted compute transaction blocks further input.
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.cmd == CMD_COMPUTE)) |=> in_stall)
    else $error("compute did not start");

  // A memory row is never read and written back in the same cycle.
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mem_wr |-> ($past(ctl.mem_rd) && !ctl.mem_rd))
    else $error("write without preceding read");

endmodule

// ===== sim/boolean_matrix_product_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boolean matrix product testbench
// Loads bits into the left and right matrices, asks for products, and checks
// every returned row against a software copy of both matrices. Both sides
// idle at random, and the receiver once holds off long enough to back the
// block up.
// ----------------------------------------------------------------------------

// Shadow copy of both matrices and the queue of product rows still owed.
class product_book;
  int unsigned        nodes;
  logic [63:0]        left_rows [64];
  logic [63:0]        right_rows [64];
  bmp_pkg::out_item_t rows_due [$];
  int unsigned        mismatches;

  function new(int unsigned node_count);
    nodes      = node_count;
    mismatches = 0;
    wipe();
  endfunction

  function void wipe();
    for (int i = 0; i < 64; i++) begin
      left_rows[i]  = '0;
      right_rows[i] = '0;
    end
  endfunction

  function int unsigned pending();
    return rows_due.size();
  endfunction

  // Applies an accepted input transaction to the shadow matrices; a compute
  // queues one product row per node.
  function void note_input(bmp_pkg::in_item_t item);
    logic               fits;
    logic [63:0]        col_mask;
    logic [63:0]        acc;
    bmp_pkg::out_item_t due;
    fits     = (item.row_index < nodes) && (item.col_index < nodes);
    col_mask = (nodes >= 64) ? '1 : ((64'd1 << nodes) - 64'd1);
    case (item.cmd)
      bmp_pkg::CMD_CLEAR: wipe();
      bmp_pkg::CMD_LEFT: begin
        if (fits) left_rows[item.row_index][item.col_index] = 1'b1;
      end
      bmp_pkg::CMD_EDGE: begin
        // A self edge lands on the same diagonal bit twice.
        if (fits) begin
          left_rows[item.row_index][item.col_index] = 1'b1;
          left_rows[item.col_index][item.row_index] = 1'b1;
        end
      end
      bmp_pkg::CMD_RIGHT: begin
        if (fits) right_rows[item.row_index][item.col_index] = 1'b1;
      end
      bmp_pkg::CMD_COMPUTE: begin
        for (int i = 0; i < int'(nodes); i++) begin
          acc = '0;
          for (int k = 0; k < int'(nodes); k++) begin
            if (left_rows[i][k]) acc |= right_rows[k];
          end
          due.out_row  = 6'(i);
          due.row_bits = acc & col_mask;
          due.last_row = (i == int'(nodes) - 1);
          rows_due.push_back(due);
        end
      end
      default: ;
    endcase
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Compares a returned row with the oldest row still owed.
  task check_row(bmp_pkg::out_item_t got);
    bmp_pkg::out_item_t due;
    if (rows_due.size() == 0) begin
      report_mismatch($sformatf("unexpected row %0d, bits %h", got.out_row, got.row_bits));
    end else begin
      due = rows_due.pop_front();
      if (got.out_row !== due.out_row)
        report_mismatch($sformatf("row index %0d, wanted %0d", got.out_row, due.out_row));
      if (got.row_bits !== due.row_bits)
        report_mismatch($sformatf("row %0d bits %h, wanted %h",
                                  due.out_row, got.row_bits, due.row_bits));
      if (got.last_row !== due.last_row)
        report_mismatch($sformatf("row %0d last flag %b, wanted %b",
                                  due.out_row, got.last_row, due.last_row));
    end
  endtask
endclass

module boolean_matrix_product_test;
  import bmp_pkg::*;

  localparam int NODES         = 64;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 170;
  localparam int SETTLE_CYCLES = 40;

  // Command codes the block leaves unused.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Set for a stretch of the run in which neither side idles.
  bit          calm        = 1'b0;
  int unsigned holds_asked = 0;

  product_book book = new(NODES);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  boolean_matrix_product #(
    .NODES(NODES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Result side: checks each accepted row and decides the next stall.
  initial begin : receiver
    int unsigned holds_served;
    int unsigned hold_left;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) book.check_row(out_data);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 9) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one transaction and returns at the edge that accepts it.
  task automatic send_item(input in_item_t item);
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_input(item);
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [5:0] row, input logic [5:0] col);
    in_item_t item;
    item.cmd       = cmd;
    item.row_index = row;
    item.col_index = col;
    send_item(item);
  endtask

  // Stops offering and waits until every owed row has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Half of the indices fall in a small corner so that products get dense.
  function automatic logic [5:0] pick_index();
    return $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
  endfunction

  initial begin : stimulus
    int unsigned live;
    int unsigned seq;
    int unsigned loads;
    int unsigned roll;
    logic [2:0]  load_cmd;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: product of empty matrices, corner bits, edges and spare codes.
    send_cmd(CMD_COMPUTE, 6'd0, 6'd0);
    send_cmd(CMD_LEFT, 6'd0, 6'd0);
    send_cmd(CMD_LEFT, 6'd63, 6'd63);
    send_cmd(CMD_LEFT, 6'd0, 6'd0);
    send_cmd(CMD_RIGHT, 6'd0, 6'd63);
    send_cmd(CMD_RIGHT, 6'd63, 6'd0);
    send_cmd(CMD_RIGHT, 6'd5, 6'd42);
    send_cmd(CMD_EDGE, 6'd0, 6'd63);
    send_cmd(CMD_EDGE, 6'd5, 6'd5);
    send_cmd(CMD_SPARE_LO, 6'd63, 6'd63);
    send_cmd(CMD_SPARE_LO + 3'd1, 6'd21, 6'd42);
    send_cmd(CMD_SPARE_HI, 6'd42, 6'd21);
    send_cmd(CMD_RIGHT, 6'd42, 6'd17);

    // The receiver holds off while the product and more loads pile up.
    holds_asked++;
    send_cmd(CMD_COMPUTE, 6'd63, 6'd63);
    send_cmd(CMD_CLEAR, 6'd63, 6'd0);
    send_cmd(CMD_LEFT, 6'd63, 6'd0);
    send_cmd(CMD_COMPUTE, 6'd0, 6'd0);
    send_cmd(CMD_RIGHT, 6'd0, 6'd21);
    send_cmd(CMD_COMPUTE, 6'd0, 6'd0);
    wait_drained();

    // Random: mostly a clear, a run of loads and a compute, with stray
    // clears and spare codes mixed in.
    live = 0;
    seq  = 0;
    while (live < RANDOM_ITEMS) begin
      calm = (seq >= 3 && seq <= 5);
      if ($urandom_range(0, 9) < 8) begin
        send_cmd(CMD_CLEAR, pick_index(), pick_index());
        live++;
      end
      loads = $urandom_range(10, 30);
      repeat (loads) begin
        roll = $urandom_range(0, 99);
        if (roll < 88) begin
          case ($urandom_range(0, 2))
            0:       load_cmd = CMD_LEFT;
            1:       load_cmd = CMD_EDGE;
            default: load_cmd = CMD_RIGHT;
          endcase
          send_cmd(load_cmd, pick_index(), pick_index());
          live++;
        end else if (roll < 92) begin
          send_cmd(CMD_CLEAR, pick_index(), pick_index());
          live++;
        end else begin
          send_cmd(CMD_SPARE_LO + 3'($urandom_range(0, CMD_SPARE_HI - CMD_SPARE_LO)),
                   pick_index(), pick_index());
        end
      end
      send_cmd(CMD_COMPUTE, pick_index(), pick_index());
      live++;
      if ($urandom_range(0, 3) == 0) wait_drained();
      seq++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung block: far beyond the slowest correct run, even if
  // every transaction were a compute.
  initial begin : watchdog
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
